### hdl/rau_pkg.sv
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int NUM_OUT_W         = 33;
    localparam int DEN_OUT_W         = 31;
    localparam int M_TDATA_W         = 72;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } rau_op_t;

    // Per-stage control that travels beside the payload
    typedef struct packed {
        logic valid;
        logic neg;
        logic less;
        logic equal;
        logic greater;
        logic err;
    } rau_ctrl_t;

endpackage

### hdl/rau_front.sv
module rau_front #(
    parameter int W = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [1:0]            op,
    input  logic [W-1:0]          ln,
    input  logic [W-1:0]          ld,
    input  logic [W-1:0]          rn,
    input  logic [W-1:0]          rd,
    output rau_pkg::rau_ctrl_t    ctrl_out,
    output logic [2*W-1:0]        mag_out,
    output logic [2*W-1:0]        den_out
);
    import rau_pkg::*;

    localparam int MW = 2 * W;
    localparam int PW = 2 * W + 2;

    // stage 1: denominators made positive
    logic                v1_reg, zero1_reg;
    rau_op_t             op1_reg;
    logic signed [W:0]   ln1_reg, ld1_reg, rn1_reg, rd1_reg;
    logic signed [W:0]   ln_x, ld_x, rn_x, rd_x;

    // stage 2: cross products
    logic                v2_reg, zero2_reg;
    rau_op_t             op2_reg;
    logic signed [PW-1:0] p_lr_reg, p_rl_reg, p_nn_reg, p_dd_reg, p_dn_reg;
    logic signed [PW-1:0] p_lr_next, p_rl_next, p_nn_next, p_dd_next, p_dn_next;

    // stage 3: select, compare, magnitude
    rau_ctrl_t           ctrl_reg, ctrl_next;
    logic [MW-1:0]       mag_reg, mag_next, den_reg, den_next;
    logic signed [PW-1:0] num_sel, den_sel, num_abs;
    logic                div_zero;

    assign ln_x = {ln[W-1], ln};
    assign ld_x = {ld[W-1], ld};
    assign rn_x = {rn[W-1], rn};
    assign rd_x = {rd[W-1], rd};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            op1_reg   <= rau_op_t'(op);
            zero1_reg <= (ld == '0) || (rd == '0);
            ln1_reg   <= ld[W-1] ? -ln_x : ln_x;
            ld1_reg   <= ld[W-1] ? -ld_x : ld_x;
            rn1_reg   <= rd[W-1] ? -rn_x : rn_x;
            rd1_reg   <= rd[W-1] ? -rd_x : rd_x;
        end
    end

    assign p_lr_next = ln1_reg * rd1_reg;
    assign p_rl_next = rn1_reg * ld1_reg;
    assign p_nn_next = ln1_reg * rn1_reg;
    assign p_dd_next = ld1_reg * rd1_reg;
    assign p_dn_next = ld1_reg * rn1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            op2_reg   <= op1_reg;
            zero2_reg <= zero1_reg;
            p_lr_reg  <= p_lr_next;
            p_rl_reg  <= p_rl_next;
            p_nn_reg  <= p_nn_next;
            p_dd_reg  <= p_dd_next;
            p_dn_reg  <= p_dn_next;
        end
    end

    always_comb begin
        num_sel  = p_lr_reg;
        den_sel  = p_dd_reg;
        div_zero = 1'b0;
        unique case (op2_reg)
            OP_ADD: num_sel = p_lr_reg + p_rl_reg;
            OP_SUB: num_sel = p_lr_reg - p_rl_reg;
            OP_MUL: num_sel = p_nn_reg;
            OP_DIV: begin
                div_zero = (p_dn_reg == '0);
                if (p_dn_reg < 0) begin
                    num_sel = -p_lr_reg;
                    den_sel = -p_dn_reg;
                end else begin
                    den_sel = p_dn_reg;
                end
            end
            default: num_sel = p_lr_reg;
        endcase
        num_abs = (num_sel < 0) ? -num_sel : num_sel;

        ctrl_next.valid   = v2_reg;
        ctrl_next.err     = zero2_reg | div_zero;
        ctrl_next.less    = !zero2_reg && (p_lr_reg < p_rl_reg);
        ctrl_next.equal   = !zero2_reg && (p_lr_reg == p_rl_reg);
        ctrl_next.greater = !zero2_reg && (p_lr_reg > p_rl_reg);
        if (zero2_reg || div_zero) begin
            ctrl_next.neg = 1'b0;
            mag_next      = '0;
            den_next      = MW'(1);
        end else begin
            ctrl_next.neg = (num_sel < 0);
            mag_next      = num_abs[MW-1:0];
            den_next      = den_sel[MW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_next;
        end
        if (en) begin
            mag_reg <= mag_next;
            den_reg <= den_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign mag_out  = mag_reg;
    assign den_out  = den_reg;

endmodule

### hdl/rau_gcd.sv
module rau_gcd #(
    parameter int W = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  rau_pkg::rau_ctrl_t ctrl_in,
    input  logic [2*W-1:0]     mag_in,
    input  logic [2*W-1:0]     den_in,
    output rau_pkg::rau_ctrl_t ctrl_out,
    output logic [2*W-1:0]     mag_out,
    output logic [2*W-1:0]     den_out,
    output logic [2*W-1:0]     gcd_out
);
    import rau_pkg::*;

    localparam int MW    = 2 * W;
    localparam int STEPS = 2 * MW;   // each binary step drops at least one bit
    localparam int KW    = $clog2(MW + 1);

    rau_ctrl_t     ctrl_pipe [STEPS+1];
    logic [MW-1:0] mag_pipe  [STEPS+1];
    logic [MW-1:0] den_pipe  [STEPS+1];
    logic [MW-1:0] a_pipe    [STEPS+1];
    logic [MW-1:0] b_pipe    [STEPS+1];
    logic [KW-1:0] k_pipe    [STEPS+1];

    rau_ctrl_t     ctrl_reg;
    logic [MW-1:0] mag_reg, den_reg, gcd_reg, gcd_next;

    assign ctrl_pipe[0] = ctrl_in;
    assign mag_pipe[0]  = mag_in;
    assign den_pipe[0]  = den_in;
    assign a_pipe[0]    = mag_in;
    assign b_pipe[0]    = den_in;
    assign k_pipe[0]    = '0;

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic [MW-1:0] a_next, b_next;
        logic [KW-1:0] k_next;

        always_comb begin
            a_next = a_pipe[i];
            b_next = b_pipe[i];
            k_next = k_pipe[i];
            priority if (a_pipe[i] == '0 || b_pipe[i] == '0) begin
                a_next = a_pipe[i];
            end else if (!a_pipe[i][0] && !b_pipe[i][0]) begin
                a_next = a_pipe[i] >> 1;
                b_next = b_pipe[i] >> 1;
                k_next = k_pipe[i] + KW'(1);
            end else if (!a_pipe[i][0]) begin
                a_next = a_pipe[i] >> 1;
            end else if (!b_pipe[i][0]) begin
                b_next = b_pipe[i] >> 1;
            end else if (a_pipe[i] >= b_pipe[i]) begin
                a_next = (a_pipe[i] - b_pipe[i]) >> 1;
            end else begin
                b_next = (b_pipe[i] - a_pipe[i]) >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctrl_pipe[i+1] <= '0;
            end else if (en) begin
                ctrl_pipe[i+1] <= ctrl_pipe[i];
            end
            if (en) begin
                mag_pipe[i+1] <= mag_pipe[i];
                den_pipe[i+1] <= den_pipe[i];
                a_pipe[i+1]   <= a_next;
                b_pipe[i+1]   <= b_next;
                k_pipe[i+1]   <= k_next;
            end
        end
    end

    // one operand is zero here; the other holds the odd part
    assign gcd_next = (a_pipe[STEPS] | b_pipe[STEPS]) << k_pipe[STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_pipe[STEPS];
        end
        if (en) begin
            mag_reg <= mag_pipe[STEPS];
            den_reg <= den_pipe[STEPS];
            gcd_reg <= gcd_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign mag_out  = mag_reg;
    assign den_out  = den_reg;
    assign gcd_out  = gcd_reg;

endmodule

### hdl/rau_div.sv
module rau_div #(
    parameter int W = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  rau_pkg::rau_ctrl_t                   ctrl_in,
    input  logic [2*W-1:0]                       mag_in,
    input  logic [2*W-1:0]                       den_in,
    input  logic [2*W-1:0]                       gcd_in,
    output rau_pkg::rau_ctrl_t                   ctrl_out,
    output logic signed [rau_pkg::NUM_OUT_W-1:0] num_out,
    output logic [rau_pkg::DEN_OUT_W-1:0]        den_out
);
    import rau_pkg::*;

    localparam int MW = 2 * W;

    // two restoring dividers sharing the divisor, one quotient bit per stage
    rau_ctrl_t     ctrl_pipe [MW+1];
    logic [MW-1:0] g_pipe    [MW+1];
    logic [MW-1:0] xa_pipe   [MW+1];
    logic [MW-1:0] xb_pipe   [MW+1];
    logic [MW:0]   ra_pipe   [MW+1];
    logic [MW:0]   rb_pipe   [MW+1];
    logic [MW-1:0] qa_pipe   [MW+1];
    logic [MW-1:0] qb_pipe   [MW+1];

    rau_ctrl_t               ctrl_reg;
    logic signed [NUM_OUT_W-1:0] num_reg;
    logic [DEN_OUT_W-1:0]    den_reg;
    logic signed [MW:0]      num_signed;

    assign ctrl_pipe[0] = ctrl_in;
    assign g_pipe[0]    = gcd_in;
    assign xa_pipe[0]   = mag_in;
    assign xb_pipe[0]   = den_in;
    assign ra_pipe[0]   = '0;
    assign rb_pipe[0]   = '0;
    assign qa_pipe[0]   = '0;
    assign qb_pipe[0]   = '0;

    for (genvar i = 0; i < MW; i++) begin : g_bit
        logic [MW:0] ta, tb, gx;
        logic        ga, gb;

        assign gx = {1'b0, g_pipe[i]};
        assign ta = {ra_pipe[i][MW-1:0], xa_pipe[i][MW-1]};
        assign tb = {rb_pipe[i][MW-1:0], xb_pipe[i][MW-1]};
        assign ga = (ta >= gx);
        assign gb = (tb >= gx);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctrl_pipe[i+1] <= '0;
            end else if (en) begin
                ctrl_pipe[i+1] <= ctrl_pipe[i];
            end
            if (en) begin
                g_pipe[i+1]  <= g_pipe[i];
                xa_pipe[i+1] <= xa_pipe[i] << 1;
                xb_pipe[i+1] <= xb_pipe[i] << 1;
                ra_pipe[i+1] <= ga ? ta - gx : ta;
                rb_pipe[i+1] <= gb ? tb - gx : tb;
                qa_pipe[i+1] <= {qa_pipe[i][MW-2:0], ga};
                qb_pipe[i+1] <= {qb_pipe[i][MW-2:0], gb};
            end
        end
    end

    assign num_signed = ctrl_pipe[MW].neg ? -{1'b0, qa_pipe[MW]} : {1'b0, qa_pipe[MW]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_pipe[MW];
        end
        if (en) begin
            num_reg <= NUM_OUT_W'(num_signed);
            den_reg <= DEN_OUT_W'(qb_pipe[MW]);
        end
    end

    assign ctrl_out = ctrl_reg;
    assign num_out  = num_reg;
    assign den_out  = den_reg;

endmodule

### hdl/rational_arithmetic_unit_top.sv
// Channel  Dir  tdata fields, lowest bit up
// s_axis   in   operation[2], left_numerator[W], left_denominator[W],
//               right_numerator[W], right_denominator[W], zero pad to bytes
// m_axis   out  result_numerator[33], result_denominator[31], left_is_less,
//               both_equal, left_is_greater, error_flag, zero pad to 72
//
// One transaction enters per cycle while m_axis is not stalled; the pipe is built from
// 3 front stages, 4*W binary GCD steps plus one shift stage, 2*W quotient
// bits of the divider pair, and the output register.
// aresetn (synchronous) clears only the valid bits and control flags along the pipe.
// A stall on m_axis freezes every stage at once; nothing is dropped or doubled.
module rational_arithmetic_unit_top #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    // operation, left_numerator, left_denominator, right_numerator,
    // right_denominator
    input  logic [((4*OPERAND_WIDTH+2+7)/8)*8-1:0]      s_axis_tdata,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // result_numerator, result_denominator, left_is_less, both_equal,
    // left_is_greater, error_flag
    output logic [rau_pkg::M_TDATA_W-1:0]               m_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready
);
    import rau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * W;
    localparam int SW = ((4 * W + 2 + 7) / 8) * 8;

    logic          en;
    rau_ctrl_t     f_ctrl, g_ctrl, d_ctrl;
    logic [MW-1:0] f_mag, f_den, g_mag, g_den, g_gcd;
    logic signed [NUM_OUT_W-1:0] d_num;
    logic [DEN_OUT_W-1:0]        d_den;

    // whole pipe advances unless the output holds an untaken result
    assign en            = !d_ctrl.valid || m_axis_tready;
    assign s_axis_tready = en;

    rau_front #(.W(W)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .op       (s_axis_tdata[1:0]),
        .ln       (s_axis_tdata[2+W-1:2]),
        .ld       (s_axis_tdata[2+2*W-1:2+W]),
        .rn       (s_axis_tdata[2+3*W-1:2+2*W]),
        .rd       (s_axis_tdata[2+4*W-1:2+3*W]),
        .ctrl_out (f_ctrl),
        .mag_out  (f_mag),
        .den_out  (f_den)
    );

    rau_gcd #(.W(W)) u_gcd (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .ctrl_in  (f_ctrl),
        .mag_in   (f_mag),
        .den_in   (f_den),
        .ctrl_out (g_ctrl),
        .mag_out  (g_mag),
        .den_out  (g_den),
        .gcd_out  (g_gcd)
    );

    rau_div #(.W(W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .ctrl_in  (g_ctrl),
        .mag_in   (g_mag),
        .den_in   (g_den),
        .gcd_in   (g_gcd),
        .ctrl_out (d_ctrl),
        .num_out  (d_num),
        .den_out  (d_den)
    );

    assign m_axis_tvalid = d_ctrl.valid;
    assign m_axis_tdata  = {4'b0000, d_ctrl.err, d_ctrl.greater, d_ctrl.equal,
                            d_ctrl.less, d_den, d_num};

    // padding bits of s_axis_tdata above the fields are ignored
    logic unused_pad;
    assign unused_pad = ^{s_axis_tdata[SW-1:0]};

    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready does not follow output occupancy");

    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && d_ctrl.err |-> d_num == '0 && d_den == DEN_OUT_W'(1))
        else $error("error result is not 0/1");

    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> d_den != '0)
        else $error("zero result denominator");

    a_cmp_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> $onehot0({d_ctrl.less, d_ctrl.equal, d_ctrl.greater}))
        else $error("more than one compare flag");

    a_cmp_present: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !d_ctrl.err |-> $onehot({d_ctrl.less, d_ctrl.equal, d_ctrl.greater}))
        else $error("no compare flag on a good result");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import rau_pkg::*;

    localparam int W        = OPERAND_WIDTH_DEF;
    localparam int S_W      = ((4*W+2+7)/8)*8;
    // pipeline latency of the DUT, summed over its stages
    localparam int LATENCY  = 6*W+5;
    localparam int WDOG_MAX = 20000;
    localparam int N_RANDOM = 880;

    // packed from the top bit down, so op lands in the lowest bits of tdata
    typedef struct packed {
        logic [W-1:0]  rd;
        logic [W-1:0]  rn;
        logic [W-1:0]  ld;
        logic [W-1:0]  ln;
        rau_op_t       op;
    } frac_pair_t;

    // num in the lowest bits, err on top
    typedef struct packed {
        logic                 err;
        logic                 greater;
        logic                 equal;
        logic                 less;
        logic [DEN_OUT_W-1:0] den;
        logic [NUM_OUT_W-1:0] num;
    } frac_result_t;

    logic             aclk;
    logic             aresetn;
    logic [S_W-1:0]   s_axis_tdata;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;

    frac_pair_t   pending_pairs[$];
    frac_result_t expected_results[$];
    int           n_sent, n_recv, n_errors, n_mismatch, wdog;
    int           op_count[4];
    bit           hold_for_drain;
    bit           stim_done;
    int           burst_left, gap_left, stall_left, run_left;

    rational_arithmetic_unit_top #(.OPERAND_WIDTH(W)) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),   // op, ln, ld, rn, rd from bit 0 up
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // num, den, less, equal, greater, err
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always begin
        aclk = 1'b1; #4;
        aclk = 1'b0; #4;
    end

    // Exact rational arithmetic with gcd reduction, in 64-bit integers.
    function automatic frac_result_t compute_fraction(frac_pair_t p);
        longint       ln, ld, rn, rd, lhs, rhs, num, den;
        longint unsigned mag, g, a, b, t;
        frac_result_t r;
        ln = longint'($signed(p.ln));
        ld = longint'($signed(p.ld));
        rn = longint'($signed(p.rn));
        rd = longint'($signed(p.rd));
        r = '0;
        num = 0;
        den = 1;
        if (ld == 0 || rd == 0) begin
            r.err = 1'b1;
        end else begin
            if (ld < 0) begin ln = -ln; ld = -ld; end
            if (rd < 0) begin rn = -rn; rd = -rd; end
            lhs = ln * rd;
            rhs = rn * ld;
            r.less    = lhs < rhs;
            r.equal   = lhs == rhs;
            r.greater = lhs > rhs;
            case (p.op)
                OP_ADD: begin num = lhs + rhs; den = ld * rd; end
                OP_SUB: begin num = lhs - rhs; den = ld * rd; end
                OP_MUL: begin num = ln * rn; den = ld * rd; end
                default: begin
                    if (rn == 0) begin
                        r.err = 1'b1;
                    end else begin
                        num = lhs;
                        den = ld * rn;
                        if (den < 0) begin num = -num; den = -den; end
                    end
                end
            endcase
            if (r.err) begin
                num = 0;
                den = 1;
            end else begin
                mag = (num < 0) ? -num : num;
                a = mag;
                b = den;
                while (b != 0) begin
                    t = a % b;
                    a = b;
                    b = t;
                end
                g = a;
                if (g > 1) begin
                    mag = mag / g;
                    den = den / g;
                    num = (num < 0) ? -longint'(mag) : longint'(mag);
                end
            end
        end
        r.num = num[NUM_OUT_W-1:0];
        r.den = den[DEN_OUT_W-1:0];
        return r;
    endfunction

    function automatic int pick_operand();
        case ($urandom_range(0, 9))
            0: return 2**(W-1) - 1;
            1: return -(2**(W-1));
            2: return 0;
            3: return int'($urandom_range(0, 8)) - 4;
            4: return int'($urandom_range(0, 60));
            default: return int'($urandom);
        endcase
    endfunction

    task automatic add_pair(rau_op_t op, int ln, int ld, int rn, int rd);
        frac_pair_t p;
        p.op = op; p.ln = W'(ln); p.ld = W'(ld); p.rn = W'(rn); p.rd = W'(rd);
        pending_pairs.push_back(p);
    endtask

    // Driver: bursts of random length with random gaps; one NBA per step.
    always @(posedge aclk) begin
        frac_pair_t p;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                p = frac_pair_t'(s_axis_tdata[4*W+1:0]);
                expected_results.push_back(compute_fraction(p));
                op_count[p.op]++;
                n_sent++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_pairs.size() == 0 || hold_for_drain) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    p = pending_pairs.pop_front();
                    s_axis_tdata  <= S_W'(p);
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 :
                                      $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // Monitor and receiver stall pattern: long open runs, short stall runs.
    always @(posedge aclk) begin
        frac_result_t got, want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            run_left      <= 0;
            wdog          <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = frac_result_t'(m_axis_tdata[NUM_OUT_W+DEN_OUT_W+3:0]);
                n_recv++;
                if (expected_results.size() == 0) begin
                    n_errors++;
                    $display("unexpected result transaction: %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $display("mismatch #%0d: num %h/%h den %h/%h",
                                     n_recv, want.num, got.num, want.den, got.den);
                            $display("  lt %b/%b eq %b/%b gt %b/%b err %b/%b",
                                     want.less, got.less, want.equal, got.equal,
                                     want.greater, got.greater, want.err, got.err);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left    <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end else if (run_left > 0) begin
                run_left      <= run_left - 1;
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
                run_left      <= $urandom_range(0, 60);
                stall_left    <= ($urandom_range(0, 2) == 0) ? 0 :
                                 $urandom_range(1, 15);
            end
            // watchdog counts cycles with no transaction on either side
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                wdog <= 0;
            else
                wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("watchdog expired after %0d idle cycles", WDOG_MAX);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int pmax, pmin;
        pmax = 2**(W-1) - 1;
        pmin = -(2**(W-1));
        aresetn        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        n_sent = 0; n_recv = 0; n_errors = 0; n_mismatch = 0;
        hold_for_drain = 1'b0;
        stim_done = 1'b0;
        op_count = '{default: 0};

        // directed: each op, extremes, zero denominators, divide by zero
        add_pair(OP_ADD, 1, 2, 1, 3);
        add_pair(OP_SUB, 1, 2, 1, 2);           // zero result
        add_pair(OP_MUL, -2, 3, 3, -4);
        add_pair(OP_DIV, 1, 2, -3, 4);
        add_pair(OP_ADD, 5, 0, 1, 1);           // left denominator zero
        add_pair(OP_SUB, 5, 1, 1, 0);           // right denominator zero
        add_pair(OP_DIV, 0, 0, 0, 0);
        add_pair(OP_DIV, 7, 3, 0, 5);           // divide by zero
        add_pair(OP_DIV, 7, -3, 0, -5);
        add_pair(OP_ADD, pmax, 1, pmax, 1);
        add_pair(OP_SUB, pmin, 1, pmax, 1);
        add_pair(OP_MUL, pmin, 1, pmin, 1);
        add_pair(OP_MUL, pmin, pmax, pmin, pmax);
        add_pair(OP_DIV, pmin, 1, 1, pmin);
        add_pair(OP_DIV, pmax, pmin, pmin, pmax);
        add_pair(OP_ADD, 1, pmin, 1, pmax);
        add_pair(OP_SUB, pmin, pmin, pmax, pmax);
        add_pair(OP_MUL, 0, pmin, pmax, -1);
        add_pair(OP_ADD, -1, -1, 1, 1);
        add_pair(OP_DIV, '1, '1, '1, '1);
        add_pair(OP_SUB, 3, 6, 1, 2);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_pairs.size() == 0);
        // let the pipe drain fully before the random traffic
        hold_for_drain = 1'b1;
        wait (expected_results.size() == 0 && !s_axis_tvalid);
        hold_for_drain = 1'b0;

        for (int i = 0; i < N_RANDOM; i++)
            add_pair(rau_op_t'($urandom_range(0, 3)), pick_operand(),
                     pick_operand(), pick_operand(), pick_operand());

        wait (pending_pairs.size() == 0);
        @(posedge aclk);
        wait (!s_axis_tvalid && expected_results.size() == 0);
        repeat (2*LATENCY) @(posedge aclk);

        $display("tb: %0d fraction pairs, %0d results (add %0d sub %0d mul %0d div %0d)",
                 n_sent, n_recv, op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("tb: %0d errors, %0d field mismatches", n_errors, n_mismatch);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
